// ===== src/wvd_pkg.sv =====
// Shared types and constants for the windowed vote detector.
package wvd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCORE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_VOTE_QUOTA      = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN_FRAMES = 2'd2;

    localparam int unsigned SCORE_W    = 8;
    localparam int unsigned NEEDED_W   = 7;
    localparam int unsigned COOLDOWN_W = 10;
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [SCORE_W-1:0]    THRESHOLD_RST = 8'd128;
    localparam logic [NEEDED_W-1:0]   NEEDED_RST    = 7'd20;
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST  = 10'd200;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX     = 7'd127;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

endpackage

// ===== src/windowed_vote_detector_with_cooldown.sv =====
// Top level of the k-of-n sliding window voter with cooldown.
// Usage:
//   s_* channel: one beat per frame, s_tdata[7:0] = score.
//   m_* channel: one beat per frame, m_tdata = {7'b0, in_cooldown,
//     vote_total[6:0], detected} from bit 15 down to bit 0.
//   cfg_* channel: register writes, always ready; index 0 score_threshold,
//     1 needed vote count, 2 cooldown_frames, other indexes ignored. Write
//     only while no frame is in flight.
// Flow:
//   A frame inside cooldown goes from accept straight to the result state,
//   with no scan. Otherwise the scan reads the score ring one entry per
//   cycle through the single read port of the window RAM, over all stored
//   scores (1 .. WINDOW_LEN, the new one included). One frame is processed
//   at a time; s_tready is low while a frame is in work.
// Reset: fill count, write slot and cooldown go to zero and the registers to
//   their defaults; the RAM needs no clearing since only filled entries
//   are read.
// Stall: a result waits in the output register; a later result waits in
//   its final state until m_tready frees that register.
module windowed_vote_detector_with_cooldown
    import wvd_pkg::*;
#(
    parameter int WINDOW_LEN = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SCORE_W-1:0]    s_tdata,    // [7:0] score
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [0] detected, [7:1] vote_total,
                                              // [8] in_cooldown, [15:9] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int CMP_W  = (FILL_W > TOTAL_W) ? FILL_W : TOTAL_W;

    // configuration
    logic [SCORE_W-1:0]    threshold_reg;
    logic [NEEDED_W-1:0]   needed_reg;
    logic [COOLDOWN_W-1:0] cool_frames_reg;

    // window state
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [COOLDOWN_W-1:0] cool_reg, cool_next;

    // scan
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [FILL_W-1:0]     count_reg, count_next;
    logic                  res_cool_reg, res_cool_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_det_reg, out_det_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic                  out_cool_reg, out_cool_next;

    logic                  accept;
    logic                  out_free;
    logic                  hit;
    logic                  ram_rd_en;
    logic [SCORE_W-1:0]    ram_rd_data;
    logic [CMP_W-1:0]      count_cmp;
    logic [CMP_W-1:0]      needed_cmp;
    logic                  detect;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign ram_rd_en = (state_reg == ST_SCAN);
    assign hit       = pend_reg && (ram_rd_data >= threshold_reg);
    assign count_cmp  = CMP_W'(count_reg);
    assign needed_cmp = CMP_W'(needed_reg);
    assign detect     = !res_cool_reg && (count_cmp >= needed_cmp);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - TOTAL_W - 2){1'b0}},
                       out_cool_reg, out_total_reg, out_det_reg};

    wvd_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RST;
            needed_reg      <= NEEDED_RST;
            cool_frames_reg <= COOLDOWN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCORE_THRESHOLD: threshold_reg   <= cfg_data[SCORE_W-1:0];
                CFG_VOTE_QUOTA:      needed_reg      <= cfg_data[NEEDED_W-1:0];
                CFG_COOLDOWN_FRAMES: cool_frames_reg <= cfg_data[COOLDOWN_W-1:0];
                default:             ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        cool_next      = cool_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        count_next     = count_reg;
        res_cool_next  = res_cool_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_det_next   = out_det_reg;
        out_total_next = out_total_reg;
        out_cool_next  = out_cool_reg;

        // one compare per returned RAM word
        if (hit)
        begin
            count_next = count_reg + FILL_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next = (slot_reg == IDX_W'(WINDOW_LEN - 1)) ? '0
                                                                     : slot_reg + IDX_W'(1);
                    if (fill_reg != FILL_W'(WINDOW_LEN))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    idx_next   = '0;
                    count_next = '0;
                    if (cool_reg != '0)
                    begin
                        cool_next     = cool_reg - COOLDOWN_W'(1);
                        res_cool_next = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        res_cool_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b1;
                if (FILL_W'(idx_reg) + FILL_W'(1) == fill_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                // last word is counted above
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cool_next  = res_cool_reg;
                    out_det_next   = detect;
                    if (res_cool_reg)
                    begin
                        out_total_next = '0;
                    end
                    else if (count_cmp > CMP_W'(TOTAL_MAX))
                    begin
                        out_total_next = TOTAL_MAX;
                    end
                    else
                    begin
                        out_total_next = count_cmp[TOTAL_W-1:0];
                    end
                    if (detect)
                    begin
                        slot_next = '0;
                        fill_next = '0;
                        cool_next = cool_frames_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            cool_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            cool_reg      <= cool_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        count_reg     <= count_next;
        res_cool_reg  <= res_cool_next;
        out_det_reg   <= out_det_next;
        out_total_reg <= out_total_next;
        out_cool_reg  <= out_cool_next;
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("fill count above window length");

    a_det_not_cool: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_det_reg && out_cool_reg))
        else $error("detection reported inside cooldown");

    a_cool_no_votes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cool_reg) |-> (out_total_reg == '0))
        else $error("votes reported inside cooldown");

    a_clear_on_det: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free && detect) |=> (fill_reg == '0))
        else $error("window not cleared after detection");

    a_scan_no_cool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cool_reg == '0))
        else $error("scan started during cooldown");
`endif

endmodule

// ===== src/wvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
